FILE: hdl/lpbu_pkg.sv
package lpbu_pkg;

    // Size marker codes that open a frame.
    localparam logic [7:0] MARK_ONE_BYTE = 8'hC0;
    localparam logic [7:0] MARK_TWO_BYTE = 8'h80;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int COUNT_W       = 15;

    // Header parser phases.
    typedef enum logic [2:0] {
        PH_MARKER = 3'd0,
        PH_LEN8   = 3'd1,
        PH_LENHI  = 3'd2,
        PH_LENLO  = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    // What the parser says about the word held in the input register.
    typedef struct packed {
        logic is_data;
        logic last;
    } t_cmd;

endpackage

FILE: hdl/length_prefixed_bit_unpacker_unit.sv
// A data word taken from the input passes through the input register and then
// the output shifter, which sends its bits out least significant first.
// Header words retire from the input register; a data word waits there until
// the single-bit output shifter is free or sending its eighth bit.
// The input register takes the next word while the shifter is still emptying.
// Reset (synchronous, active low) clears the valid flags and sets the parser
// to await a size marker with a zero count.
module length_prefixed_bit_unpacker_unit
    import lpbu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_bit_value,
    output logic       o_frame_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_cmd w_cmd;
    logic w_can_load;
    logic w_consume;
    logic w_load;
    logic w_in_take;

    // Header words always retire; data words wait for the shifter.
    assign w_consume = r_in_valid && (!w_cmd.is_data || w_can_load);
    assign w_load    = r_in_valid && w_cmd.is_data && w_can_load;
    assign o_stall   = r_in_valid && !w_consume;
    assign w_in_take = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_in_byte;
        end
    end

    lpbu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_take  (w_consume),
        .o_cmd   (w_cmd)
    );

    lpbu_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_byte       (r_in_byte),
        .i_last       (w_cmd.last),
        .i_stall      (i_stall),
        .o_can_load   (w_can_load),
        .o_valid      (o_valid),
        .o_bit_value  (o_bit_value),
        .o_frame_last (o_frame_last)
    );

    // A held word that cannot retire must be a data word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_consume) |-> w_cmd.is_data)
        else $error("header word blocked in input register");

    // A blocked word stays in the input register unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_consume) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("blocked input word lost or changed");

    // Loading the shifter implies the output side is free or finishing.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!o_valid || !i_stall))
        else $error("shifter loaded while a stalled word is pending");

endmodule

FILE: hdl/lpbu_decode.sv
module lpbu_decode
    import lpbu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output t_cmd       o_cmd
);

    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_bytes_left, n_bytes_left;
    logic [7:0]           r_length_high, n_length_high;

    logic [COUNT_W-1:0]   w_count;
    logic                 w_start;

    // Next state: walk the frame header and count down the data words.
    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_length_high = r_length_high;
        w_count       = '0;
        w_start       = 1'b0;
        if (i_take) begin
            case (r_phase)
                PH_LEN8: begin
                    w_count = {{(COUNT_W-8){1'b0}}, i_byte};
                    w_start = 1'b1;
                end
                PH_LENHI: begin
                    n_length_high = i_byte;
                    n_phase       = PH_LENLO;
                end
                PH_LENLO: begin
                    if (r_length_high[7]) begin
                        n_phase      = PH_MARKER;
                        n_bytes_left = '0;
                    end else begin
                        w_count = {r_length_high[6:0], i_byte};
                        w_start = 1'b1;
                    end
                end
                PH_DATA: begin
                    if (r_bytes_left != '0) begin
                        n_bytes_left = r_bytes_left - 1'b1;
                        if (r_bytes_left == {{(COUNT_W-1){1'b0}}, 1'b1}) begin
                            n_phase = PH_MARKER;
                        end
                    end else if (i_byte == MARK_ONE_BYTE) begin
                        n_phase = PH_LEN8;
                    end else if (i_byte == MARK_TWO_BYTE) begin
                        n_phase = PH_LENHI;
                    end else begin
                        w_count = {{(COUNT_W-8){1'b0}}, i_byte};
                        w_start = 1'b1;
                    end
                end
                default: begin
                    if (i_byte == MARK_ONE_BYTE) begin
                        n_phase = PH_LEN8;
                    end else if (i_byte == MARK_TWO_BYTE) begin
                        n_phase = PH_LENHI;
                    end else begin
                        w_count = {{(COUNT_W-8){1'b0}}, i_byte};
                        w_start = 1'b1;
                    end
                end
            endcase
            // A zero count closes the frame at once.
            if (w_start) begin
                if (w_count == '0) begin
                    n_phase      = PH_MARKER;
                    n_bytes_left = '0;
                end else begin
                    n_phase      = PH_DATA;
                    n_bytes_left = w_count;
                end
            end
        end
    end

    // Outputs: the held word is a data word while data words remain.
    always_comb begin
        o_cmd.is_data = (r_phase == PH_DATA) && (r_bytes_left != '0);
        o_cmd.last    = (r_bytes_left == {{(COUNT_W-1){1'b0}}, 1'b1});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MARKER;
            r_bytes_left  <= '0;
            r_length_high <= '0;
        end else begin
            r_phase       <= n_phase;
            r_bytes_left  <= n_bytes_left;
            r_length_high <= n_length_high;
        end
    end

endmodule

FILE: hdl/lpbu_serial.sv
module lpbu_serial
    import lpbu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_stall,
    output logic       o_can_load,
    output logic       o_valid,
    output logic       o_bit_value,
    output logic       o_frame_last
);

    logic                 r_busy;
    logic [7:0]           r_shift;
    logic                 r_last;
    logic [BIT_IDX_W-1:0] r_idx;

    logic w_out_take;
    logic w_final_bit;

    localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(BITS_PER_BYTE - 1);

    assign w_out_take  = r_busy && !i_stall;
    assign w_final_bit = (r_idx == LAST_IDX);

    // A new word may enter once the shifter is empty or its eighth bit leaves now.
    assign o_can_load   = !r_busy || (w_out_take && w_final_bit);
    assign o_valid      = r_busy;
    assign o_bit_value  = r_shift[0];
    assign o_frame_last = r_last && w_final_bit;

    // Control of the shifter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_out_take) begin
            r_idx <= r_idx + 1'b1;
            if (w_final_bit) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Payload: bits leave least significant first.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= i_byte;
            r_last  <= i_last;
        end else if (w_out_take) begin
            r_shift <= {1'b0, r_shift[7:1]};
        end
    end

endmodule
